// File: rtl/core/desq_pkg.sv
// ----------------------------------------------------------------------------
// desq_pkg
// Shared types, command codes and the scaling function of the double-ended
// queue.
// ----------------------------------------------------------------------------
package desq_pkg;

    typedef enum logic [2:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_QUERY      = 3'd4,
        CMD_CLEAR      = 3'd5,
        CMD_SCALE      = 3'd6
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_POP   = 2'd1,
        S_SCALE = 2'd2
    } t_state;

    // memory port controls from the sequencer
    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic wr_scale;
    } t_mem_ctrl;

    localparam int          SCALE_SHIFT = 10;
    localparam logic [31:0] SCALE_LIMIT = 32'd2097151;
    localparam logic [31:0] SAT_VALUE   = 32'h7FFF_FFFF;
    localparam logic [31:0] EMPTY_VALUE = 32'hFFFF_FFFF;

    // negative words compare above the limit as unsigned and saturate too
    function automatic logic [31:0] scale_word(input logic [31:0] w);
        logic [31:0] r;
        if (w > SCALE_LIMIT) begin
            r = SAT_VALUE;
        end else begin
            r = w << SCALE_SHIFT;
        end
        return r;
    endfunction

endpackage

// File: rtl/core/desq_if.sv
// ----------------------------------------------------------------------------
// desq_if
// Valid/ready channels carrying the command item and the result item.
// ----------------------------------------------------------------------------
interface desq_in_if;
    logic               valid;
    logic               ready;
    logic        [2:0]  command;
    logic signed [31:0] value;

    modport source (output valid, output command, output value, input ready);
    modport sink   (input valid, input command, input value, output ready);
endinterface

interface desq_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] popped_value;
    logic        [10:0] entry_count;
    logic        [1:0]  status;

    modport source (output valid, output popped_value, output entry_count, output status,
                    input ready);
    modport sink   (input valid, input popped_value, input entry_count, input status,
                    output ready);
endinterface

// File: rtl/core/desq_store.sv
// ----------------------------------------------------------------------------
// desq_store
// Ring buffer memory: one registered read port and one write port that
// takes either a pushed word or the scaled copy of the last word read.
// ----------------------------------------------------------------------------
module desq_store #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic                  i_clk,
    input  desq_pkg::t_mem_ctrl   i_ctrl,
    input  logic [AW-1:0]         i_rd_addr,
    input  logic [AW-1:0]         i_wr_addr,
    input  logic [31:0]           i_wr_data,
    output logic [31:0]           o_rd_data
);
    import desq_pkg::*;

    logic [31:0] r_mem [DEPTH];
    logic [31:0] r_rd_data;
    logic [31:0] w_wr_word;

    // read-modify-write path for the scale walk
    assign w_wr_word = i_ctrl.wr_scale ? scale_word(r_rd_data) : i_wr_data;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr_en) begin
            r_mem[i_wr_addr] <= w_wr_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/core/double_ended_queue_with_scaling_top.sv
// ----------------------------------------------------------------------------
// double_ended_queue_with_scaling_top
// Bounded double-ended queue of signed words with push/pop at both ends,
// query, clear and an in-place saturating scale-by-1024 of all entries.
// ----------------------------------------------------------------------------
// Every command item returns exactly one result item carrying the entry count
// after the command. Push, query, clear and a pop on an empty queue write
// their result straight into the result register; a pop that returns a word
// passes through the S_POP state first, since the word comes out of the
// single memory's registered read port. Scale walks the stored entries
// through the memory read and write ports, one entry per cycle, and no
// command is taken meanwhile. A new command is taken as soon as the result
// register is free or being emptied in the same cycle. The memory needs no
// clearing after reset: only slots that hold queued words are ever read.
module double_ended_queue_with_scaling_top #(
    parameter int QUEUE_DEPTH = 1024
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    desq_in_if.sink      i_in,
    desq_out_if.source   o_out
);
    import desq_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    localparam logic [AW-1:0] Last_slot = AW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] Full_count = CW'(QUEUE_DEPTH);
    localparam logic [CW:0]   Sum_depth = (CW+1)'(QUEUE_DEPTH);

    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                              input logic [CW-1:0] off);
        logic [CW:0] s;
        s = (CW+1)'(base) + (CW+1)'(off);
        if (s >= Sum_depth) begin
            s = s - Sum_depth;
        end
        return s[AW-1:0];
    endfunction

    t_state          r_state, n_state;
    logic [AW-1:0]   r_front, n_front;
    logic [CW-1:0]   r_count, n_count;
    logic [CW-1:0]   r_scan, n_scan;
    logic [AW-1:0]   r_scan_addr, n_scan_addr;
    logic            r_wr_pend, n_wr_pend;
    logic [AW-1:0]   r_wr_addr, n_wr_addr;
    logic            r_out_valid, n_out_valid;
    logic [31:0]     r_out_pop, n_out_pop;
    logic [CW-1:0]   r_out_count, n_out_count;
    t_status         r_out_status, n_out_status;

    t_mem_ctrl       w_mem_ctrl;
    logic [AW-1:0]   w_rd_addr;
    logic [AW-1:0]   w_wr_addr;
    logic [31:0]     w_rd_data;
    logic            w_accept;
    t_cmd            w_cmd;
    logic [CW+10:0]  w_count_ext;

    assign i_in.ready = (r_state == S_IDLE) && (!r_out_valid || o_out.ready);
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_cmd      = t_cmd'(i_in.command);

    desq_store #(
        .DEPTH (QUEUE_DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_ctrl    (w_mem_ctrl),
        .i_rd_addr (w_rd_addr),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (i_in.value),
        .o_rd_data (w_rd_data)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if ((w_cmd == CMD_POP_FRONT || w_cmd == CMD_POP_BACK) && r_count != '0) begin
                        n_state = S_POP;
                    end else if (w_cmd == CMD_SCALE) begin
                        n_state = S_SCALE;
                    end
                end
            end
            S_POP: begin
                n_state = S_IDLE;
            end
            S_SCALE: begin
                if (r_scan == r_count && !r_wr_pend) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // datapath and memory controls
    always_comb begin
        n_front      = r_front;
        n_count      = r_count;
        n_scan       = r_scan;
        n_scan_addr  = r_scan_addr;
        n_wr_pend    = 1'b0;
        n_wr_addr    = r_wr_addr;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_out_pop    = r_out_pop;
        n_out_count  = r_out_count;
        n_out_status = r_out_status;
        w_mem_ctrl   = '0;
        w_rd_addr    = r_scan_addr;
        w_wr_addr    = r_wr_addr;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_out_pop    = '0;
                    n_out_status = ST_OK;
                    n_out_valid  = 1'b1;
                    unique case (w_cmd)
                        CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                            if (r_count == Full_count) begin
                                n_out_status = ST_FULL;
                            end else begin
                                w_mem_ctrl.wr_en = 1'b1;
                                if (w_cmd == CMD_PUSH_FRONT) begin
                                    n_front   = (r_front == '0) ? Last_slot : r_front - 1'b1;
                                    w_wr_addr = n_front;
                                end else begin
                                    w_wr_addr = slot_of(r_front, r_count);
                                end
                                n_count = r_count + 1'b1;
                            end
                        end
                        CMD_POP_FRONT, CMD_POP_BACK: begin
                            if (r_count == '0) begin
                                n_out_pop    = EMPTY_VALUE;
                                n_out_status = ST_EMPTY;
                            end else begin
                                // result waits for the read data
                                n_out_valid      = 1'b0;
                                w_mem_ctrl.rd_en = 1'b1;
                                if (w_cmd == CMD_POP_FRONT) begin
                                    w_rd_addr = r_front;
                                    n_front   = (r_front == Last_slot) ? '0 : r_front + 1'b1;
                                end else begin
                                    w_rd_addr = slot_of(r_front, r_count - 1'b1);
                                end
                                n_count = r_count - 1'b1;
                            end
                        end
                        CMD_CLEAR: begin
                            n_count = '0;
                            n_front = '0;
                        end
                        CMD_SCALE: begin
                            n_out_valid = 1'b0;
                            n_scan      = '0;
                            n_scan_addr = r_front;
                        end
                        default: begin
                        end
                    endcase
                    n_out_count = n_count;
                end
            end
            S_POP: begin
                n_out_valid  = 1'b1;
                n_out_pop    = w_rd_data;
                n_out_status = ST_OK;
                n_out_count  = r_count;
            end
            S_SCALE: begin
                // read entry k while entry k-1 is written back
                if (r_scan != r_count) begin
                    w_mem_ctrl.rd_en = 1'b1;
                    w_rd_addr        = r_scan_addr;
                    n_wr_pend        = 1'b1;
                    n_wr_addr        = r_scan_addr;
                    n_scan           = r_scan + 1'b1;
                    n_scan_addr      = (r_scan_addr == Last_slot) ? '0 : r_scan_addr + 1'b1;
                end
                if (r_wr_pend) begin
                    w_mem_ctrl.wr_en    = 1'b1;
                    w_mem_ctrl.wr_scale = 1'b1;
                    w_wr_addr           = r_wr_addr;
                end
                if (r_scan == r_count && !r_wr_pend) begin
                    n_out_valid  = 1'b1;
                    n_out_pop    = '0;
                    n_out_status = ST_OK;
                    n_out_count  = r_count;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_front     <= '0;
            r_count     <= '0;
            r_wr_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_front     <= n_front;
            r_count     <= n_count;
            r_wr_pend   <= n_wr_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_scan       <= n_scan;
        r_scan_addr  <= n_scan_addr;
        r_wr_addr    <= n_wr_addr;
        r_out_pop    <= n_out_pop;
        r_out_count  <= n_out_count;
        r_out_status <= n_out_status;
    end

    assign w_count_ext        = {11'b0, r_out_count};
    assign o_out.valid        = r_out_valid;
    assign o_out.popped_value = r_out_pop;
    assign o_out.entry_count  = w_count_ext[10:0];
    assign o_out.status       = r_out_status;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= Full_count)
        else $error("entry count above queue depth");

    a_pop_follows_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POP) |-> $past(w_accept))
        else $error("pop read state without an accepted pop");

    a_scale_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCALE && n_state == S_IDLE) |-> (!r_wr_pend && n_out_valid))
        else $error("scale finished with a write still pending");

endmodule
